// File: hw/rtl/dlfc_pkg.sv
// Shared types and constants of the delimited line field cutter.
`default_nettype none
package dlfc_pkg;
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_MAP   = 2'd1;
	localparam logic [1:0] OP_EOS   = 2'd2;
	localparam logic       CFG_MODE = 1'b0;
	localparam logic       CFG_DELIM = 1'b1;
	localparam logic [7:0] NEWLINE  = 8'd10;
	localparam logic [7:0] TAB      = 8'd9;
	localparam int         MAP_WORDS = 16;
	localparam int         FIELD_W  = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DUMP,
		ST_FLUSH,
		ST_NL
	} state_t;

	typedef struct packed {
		logic load;
		logic look;
		logic dump_start;
		logic dump_step;
		logic flush;
		logic put_nl;
		logic clear_line;
	} cmd_t;

	typedef struct packed {
		logic is_byte;
		logic is_eos;
		logic is_nl;
		logic line_empty;
		logic need_dump;
		logic dump_done;
		logic pack_busy;
		logic out_full;
	} sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/dlfc_ctrl.sv
// Controller state machine of the delimited line field cutter.
`default_nettype none
module dlfc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire dlfc_pkg::sts_t  sts,
	output dlfc_pkg::cmd_t       cmd
);
	dlfc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dlfc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlfc_pkg::ST_IDLE: if (in_valid) state_d = dlfc_pkg::ST_LOOKUP;
			dlfc_pkg::ST_LOOKUP: begin
				if (sts.is_nl || (sts.is_eos && !sts.line_empty))
					state_d = sts.need_dump ? dlfc_pkg::ST_DUMP : dlfc_pkg::ST_NL;
				else if (sts.is_byte)
					state_d = dlfc_pkg::ST_FLUSH;
				else
					state_d = dlfc_pkg::ST_IDLE;
			end
			dlfc_pkg::ST_DUMP: if (sts.dump_done && !sts.out_full) state_d = dlfc_pkg::ST_NL;
			dlfc_pkg::ST_NL:   if (!sts.out_full) state_d = dlfc_pkg::ST_FLUSH;
			dlfc_pkg::ST_FLUSH: if (!sts.pack_busy) state_d = dlfc_pkg::ST_IDLE;
			default: state_d = dlfc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dlfc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dlfc_pkg::ST_LOOKUP: begin
				cmd.look = 1'b1;
				cmd.dump_start = sts.need_dump && (sts.is_nl || (sts.is_eos && !sts.line_empty));
				cmd.clear_line = sts.is_eos && sts.line_empty;
			end
			dlfc_pkg::ST_DUMP: cmd.dump_step = !sts.out_full;
			dlfc_pkg::ST_NL: begin
				cmd.put_nl = !sts.out_full;
				cmd.clear_line = !sts.out_full;
			end
			dlfc_pkg::ST_FLUSH: cmd.flush = 1'b1;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == dlfc_pkg::ST_IDLE) else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == dlfc_pkg::ST_LOOKUP) else $error("load without lookup");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlfc_pkg::ST_NL && !sts.out_full) |=> state_q == dlfc_pkg::ST_FLUSH)
		else $error("newline not followed by flush");
endmodule
`default_nettype wire

// File: hw/rtl/dlfc_datapath.sv
// Datapath of the delimited line field cutter: map, line state, held bytes and packer.
`default_nettype none
module dlfc_datapath #(
	parameter int MAP_POSITIONS = 1024,
	parameter int LINE_LIMIT = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dlfc_pkg::cmd_t  cmd,
	output dlfc_pkg::sts_t       sts,
	input  wire logic [1:0]      opcode,
	input  wire logic [7:0]      data_byte,
	input  wire logic [3:0]      map_index,
	input  wire logic [63:0]     map_word,
	input  wire logic            cfg_valid,
	input  wire logic            cfg_index,
	input  wire logic            cfg_hi_zero,
	input  wire logic [7:0]      cfg_data,
	output logic                 m_valid,
	input  wire logic            m_ready,
	output logic [63:0]          m_bytes,
	output logic [3:0]           m_count,
	output logic                 m_last
);
	localparam int LEN_W = $clog2(LINE_LIMIT + 1);
	localparam int HIDX_W = $clog2(LINE_LIMIT);
	localparam int FW = dlfc_pkg::FIELD_W;

	logic [63:0] map_q [dlfc_pkg::MAP_WORDS];
	logic [dlfc_pkg::MAP_WORDS-1:0] mapv_q;
	logic [7:0] held_q [LINE_LIMIT];
	logic [7:0] held_rd_q;
	logic mode_q;
	logic [7:0] delim_q;
	logic [1:0] op_q;
	logic [7:0] byte_q;
	logic [3:0] midx_q;
	logic [63:0] mword_q;
	logic [FW-1:0] pc_q;
	logic [LEN_W-1:0] len_q;
	logic dseen_q, femit_q;
	logic [LEN_W-1:0] dump_q;
	logic dump_v_q;
	logic [63:0] acc_q;
	logic [3:0] acc_n_q;

	function automatic logic marked(input logic [FW-1:0] pos,
		input logic [63:0] mp [dlfc_pkg::MAP_WORDS],
		input logic [dlfc_pkg::MAP_WORDS-1:0] mv);
		logic [FW-1:0] idx;
		logic r;
		idx = pos - FW'(1);
		r = 1'b0;
		if (pos != '0 && {1'b0, pos} <= (FW+1)'(MAP_POSITIONS) && idx[FW-1:6] < 5'd16)
			r = mv[idx[9:6]] & mp[idx[9:6]][idx[5:0]];
		return r;
	endfunction

	logic is_delim, in_line, m1, mnext, mcur, mpos, emit_v;
	logic [FW-1:0] pc_next;
	logic [FW-1:0] pos_w;
	assign is_delim = byte_q == delim_q;
	assign in_line = {1'b0, len_q} < (LEN_W+1)'(LINE_LIMIT);
	assign pc_next = pc_q + FW'(1);
	assign pos_w = FW'(len_q) + FW'(1);
	assign m1 = marked(FW'(1), map_q, mapv_q);
	assign mnext = marked(pc_next, map_q, mapv_q);
	assign mcur = marked(pc_q, map_q, mapv_q);
	assign mpos = marked(pos_w, map_q, mapv_q);

	always_comb begin
		emit_v = 1'b0;
		if (op_q == dlfc_pkg::OP_BYTE && byte_q != dlfc_pkg::NEWLINE && in_line) begin
			if (mode_q) emit_v = is_delim ? (mnext && (dseen_q ? femit_q : m1)) : mcur;
			else emit_v = mpos;
		end
	end

	assign sts.is_byte = op_q == dlfc_pkg::OP_BYTE && byte_q != dlfc_pkg::NEWLINE;
	assign sts.is_eos = op_q == dlfc_pkg::OP_EOS;
	assign sts.is_nl = op_q == dlfc_pkg::OP_BYTE && byte_q == dlfc_pkg::NEWLINE;
	assign sts.line_empty = len_q == '0;
	assign sts.need_dump = mode_q && !dseen_q && !m1 && len_q != '0;
	assign sts.dump_done = !(dump_q < len_q);
	assign sts.pack_busy = m_valid && !m_ready;
	assign sts.out_full = acc_n_q == 4'd8 || (m_valid && !m_ready && acc_n_q == 4'd8);

	logic push;
	logic [7:0] push_b;
	always_comb begin
		push = 1'b0;
		push_b = byte_q;
		if (cmd.look && emit_v) push = 1'b1;
		if (cmd.dump_step && dump_v_q) begin push = 1'b1; push_b = held_rd_q; end
		if (cmd.put_nl) begin push = 1'b1; push_b = dlfc_pkg::NEWLINE; end
	end

	logic send;
	logic send_last;
	assign send_last = cmd.flush;
	assign send = (!m_valid || m_ready) && acc_n_q != '0 &&
		(acc_n_q == 4'd8 || cmd.flush);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode; byte_q <= data_byte; midx_q <= map_index; mword_q <= map_word;
		end
		if (cmd.look && op_q == dlfc_pkg::OP_MAP) map_q[midx_q] <= mword_q;
		if (cmd.look && sts.is_byte && in_line && !dseen_q && !is_delim)
			held_q[len_q[HIDX_W-1:0]] <= byte_q;
		if (cmd.dump_step) held_rd_q <= held_q[dump_q[HIDX_W-1:0]];
		if (send) m_bytes <= acc_q;
		if (send) m_count <= acc_n_q;
		if (send) m_last <= send_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapv_q <= '0; mode_q <= 1'b0; delim_q <= dlfc_pkg::TAB;
			pc_q <= FW'(1); len_q <= '0; dseen_q <= 1'b0; femit_q <= 1'b0;
			dump_q <= '0; dump_v_q <= 1'b0; acc_q <= '0; acc_n_q <= '0; m_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_hi_zero) begin
				if (cfg_index == dlfc_pkg::CFG_MODE) mode_q <= cfg_data[0];
				else delim_q <= cfg_data;
			end
			if (cmd.look && op_q == dlfc_pkg::OP_MAP) mapv_q[midx_q] <= 1'b1;
			if (cmd.look && sts.is_byte && in_line) begin
				len_q <= len_q + LEN_W'(1);
				if (is_delim) begin
					pc_q <= pc_next;
					if (!dseen_q) dseen_q <= 1'b1;
					if (mnext) femit_q <= 1'b1;
					else if (!dseen_q) femit_q <= m1;
				end
			end
			if (cmd.dump_start) begin dump_q <= '0; dump_v_q <= 1'b0; end
			if (cmd.dump_step) begin
				if (!dump_v_q) begin dump_v_q <= 1'b1; dump_q <= dump_q + LEN_W'(1); end
				else if (!sts.dump_done) dump_q <= dump_q + LEN_W'(1);
				else dump_v_q <= 1'b0;
			end
			if (cmd.clear_line) begin
				pc_q <= FW'(1); len_q <= '0; dseen_q <= 1'b0; femit_q <= 1'b0;
			end
			if (send) m_valid <= 1'b1;
			else if (m_ready) m_valid <= 1'b0;
			if (send) begin
				acc_q <= push ? {56'd0, push_b} : 64'd0;
				acc_n_q <= push ? 4'd1 : 4'd0;
			end else if (push) begin
				acc_q[{acc_n_q[2:0], 3'b000} +: 8] <= push_b;
				acc_n_q <= acc_n_q + 4'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		acc_n_q <= 4'd8) else $error("packer overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		send |=> m_valid && m_count != 4'd0) else $error("empty word sent");
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_LIMIT)) else $error("line length overran");
endmodule
`default_nettype wire

// File: hw/rtl/delimited_line_field_cutter_top.sv
// Top level of the delimited line field cutter.
// Input words on s_axis carry text bytes, map writes or end of stream, one at a time.
// A map write, an unused opcode or an end of stream on an empty line passes through
// accept and lookup. A text byte passes through accept, lookup and flush.
// A newline, or an end of stream that ends a line, passes through accept, lookup,
// newline and flush.
// In field mode a line with no delimiter and field one unmarked first replays its
// held bytes before the newline.
// A kept text byte enters the packer during lookup and leaves on m_axis from flush.
// Output words carry up to eight bytes; tlast marks the final word of an input word.
// While the receiver stalls, a waiting word holds the block in flush, newline or
// replay and s_axis_tready stays low; the packer keeps its bytes.
// Reset clears the map, the line state and the registers (mode 0, delimiter tab).
// Configuration writes are taken at any time and are meant for an idle block.
`default_nettype none
module delimited_line_field_cutter_top #(
	parameter int MAP_POSITIONS = 1024,
	parameter int LINE_LIMIT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // opcode, data_byte, map_index, map_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // out_bytes, out_count
	output logic             m_axis_tlast,  // last_of_run
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_index,
	input  wire logic [7:0]  cfg_data
);
	dlfc_pkg::cmd_t cmd;
	dlfc_pkg::sts_t sts;
	logic [3:0] cnt;
	assign cfg_ready = 1'b1;

	dlfc_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts, .cmd);

	dlfc_datapath #(.MAP_POSITIONS(MAP_POSITIONS), .LINE_LIMIT(LINE_LIMIT)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.opcode(s_axis_tdata[1:0]), .data_byte(s_axis_tdata[9:2]),
		.map_index(s_axis_tdata[13:10]), .map_word(s_axis_tdata[77:14]),
		.cfg_valid, .cfg_index(cfg_index[0]), .cfg_hi_zero(cfg_index[31:1] == '0),
		.cfg_data,
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_bytes(m_axis_tdata[63:0]),
		.m_count(cnt), .m_last(m_axis_tlast));

	assign m_axis_tdata[71:64] = {4'd0, cnt};
endmodule
`default_nettype wire
